### rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared constants, result record and back-end sequencer states for the
// pixel pair correlation block.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int MAX_REGION_DIM_DEF = 1024;

  // fixed port widths
  localparam int SAMPLE_W     = 16;
  localparam int CORR_W       = 16;
  localparam int PAIR_COUNT_W = 21;

  // Q1.15 result; the search compares (2m-1)^2 against a 2^32 scaled cov^2
  localparam int CORR_FRAC = 15;
  localparam int SCALE_SH  = 2 * (CORR_FRAC + 1);
  localparam int SRCH_BW   = $clog2(CORR_FRAC + 1);

  // region results waiting between front and back
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic signed [CORR_W-1:0]       corr;
    logic                           degen;
    logic        [PAIR_COUNT_W-1:0] count;
  } ppc_result_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_VXA,
    BK_VXB,
    BK_VYA,
    BK_VYB,
    BK_CVA,
    BK_CVB,
    BK_PV,
    BK_LHS,
    BK_SD,
    BK_ST,
    BK_OUT
  } bk_state_t;

endpackage

### rtl/pixel_pair_correlation.sv
// ----------------------------------------------------------------------------
// pixel_pair_correlation
// Pearson correlation of two pixel regions, signed Q1.15 result per region.
// ----------------------------------------------------------------------------
// Pixel pairs are taken one a cycle into exact running sums; the last pair of
// a region moves the totals into a two-entry queue and clears the sums, so the
// next region streams in without a gap. The back end works one region at a
// time on a single bit-serial shift-add multiplier: six products for the
// variances and covariance, two for the search operands and then up to two
// per bit of a sixteen-step search. Input beats stall only while two finished
// regions wait in the queue. Results pass through an output register.
module pixel_pair_correlation import ppc_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int MAX_REGION_DIM = MAX_REGION_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic        [SAMPLE_W-1:0]     in_first_sample,
  input  logic        [SAMPLE_W-1:0]     in_second_sample,
  input  logic                           in_last_pair,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [CORR_W-1:0]       out_correlation,
  output logic                           out_degenerate,
  output logic        [PAIR_COUNT_W-1:0] out_pair_count
);

  localparam int MAX_PAIRS = MAX_REGION_DIM * MAX_REGION_DIM;
  localparam int LOG_P     = $clog2(MAX_PAIRS);
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int SUM_W     = SAMPLE_BITS + LOG_P;
  localparam int SQ_W      = 2 * SAMPLE_BITS + LOG_P;
  localparam int SNAP_W    = CNT_W + 2 * SUM_W + 3 * SQ_W;

  logic              q_push, q_full, q_pop, q_empty;
  logic [SNAP_W-1:0] q_wdata, q_rdata;
  ppc_result_t       res;

  ppc_front #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MAX_REGION_DIM (MAX_REGION_DIM)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_sample  (in_first_sample),
    .in_second_sample (in_second_sample),
    .in_last_pair     (in_last_pair),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_wdata)
  );

  ppc_fifo #(
    .WIDTH (SNAP_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  ppc_back #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .MAX_REGION_DIM (MAX_REGION_DIM)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_correlation = res.corr;
  assign out_degenerate  = res.degen;
  assign out_pair_count  = res.count;

endmodule

### rtl/ppc_front.sv
// ----------------------------------------------------------------------------
// ppc_front
// Accumulates count and exact sums of x, y, xy, xx, yy; on the last pair of a
// region pushes the totals into the queue and clears them.
// ----------------------------------------------------------------------------
module ppc_front import ppc_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int MAX_REGION_DIM = MAX_REGION_DIM_DEF,
  localparam int MAX_PAIRS = MAX_REGION_DIM * MAX_REGION_DIM,
  localparam int LOG_P     = $clog2(MAX_PAIRS),
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1),
  localparam int SUM_W     = SAMPLE_BITS + LOG_P,
  localparam int SQ_W      = 2 * SAMPLE_BITS + LOG_P,
  localparam int SNAP_W    = CNT_W + 2 * SUM_W + 3 * SQ_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] in_first_sample,
  input  logic [SAMPLE_W-1:0] in_second_sample,
  input  logic                in_last_pair,
  input  logic                q_full,
  output logic                q_push,
  output logic [SNAP_W-1:0]   q_data
);

  localparam int PR_W = 2 * SAMPLE_BITS;

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic [SUM_W-1:0] sx_r, sx_nxt, sx_upd, sy_r, sy_nxt, sy_upd;
  logic [SQ_W-1:0]  sxy_r, sxy_nxt, sxy_upd;
  logic [SQ_W-1:0]  sxx_r, sxx_nxt, sxx_upd, syy_r, syy_nxt, syy_upd;
  logic [SAMPLE_BITS-1:0] x, y;
  logic [PR_W-1:0]  xy, xx, yy;
  logic             accept, take;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign x  = in_first_sample[SAMPLE_BITS-1:0];
  assign y  = in_second_sample[SAMPLE_BITS-1:0];
  assign xy = PR_W'(x) * PR_W'(y);
  assign xx = PR_W'(x) * PR_W'(x);
  assign yy = PR_W'(y) * PR_W'(y);

  // pairs beyond the region limit are dropped from the sums
  assign take = cnt_r < CNT_W'(MAX_PAIRS);

  always_comb begin
    cnt_upd = cnt_r;
    sx_upd  = sx_r;
    sy_upd  = sy_r;
    sxy_upd = sxy_r;
    sxx_upd = sxx_r;
    syy_upd = syy_r;
    if (take) begin
      cnt_upd = cnt_r + CNT_W'(1);
      sx_upd  = sx_r + SUM_W'(x);
      sy_upd  = sy_r + SUM_W'(y);
      sxy_upd = sxy_r + SQ_W'(xy);
      sxx_upd = sxx_r + SQ_W'(xx);
      syy_upd = syy_r + SQ_W'(yy);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sxy_nxt = sxy_r;
    sxx_nxt = sxx_r;
    syy_nxt = syy_r;
    q_push  = 1'b0;
    if (accept) begin
      if (in_last_pair) begin
        q_push  = 1'b1;
        cnt_nxt = '0;
        sx_nxt  = '0;
        sy_nxt  = '0;
        sxy_nxt = '0;
        sxx_nxt = '0;
        syy_nxt = '0;
      end else begin
        cnt_nxt = cnt_upd;
        sx_nxt  = sx_upd;
        sy_nxt  = sy_upd;
        sxy_nxt = sxy_upd;
        sxx_nxt = sxx_upd;
        syy_nxt = syy_upd;
      end
    end
  end

  assign q_data = {cnt_upd, sx_upd, sy_upd, sxy_upd, sxx_upd, syy_upd};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxy_r <= '0;
      sxx_r <= '0;
      syy_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sxy_r <= sxy_nxt;
      sxx_r <= sxx_nxt;
      syy_r <= syy_nxt;
    end
  end

endmodule

### rtl/ppc_fifo.sv
// ----------------------------------------------------------------------------
// ppc_fifo
// Short queue of region totals between the accumulator and the back end.
// ----------------------------------------------------------------------------
module ppc_fifo import ppc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("region totals pushed into a full queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(DEPTH))
    else $error("queue fill count out of range");

endmodule

### rtl/ppc_mul.sv
// ----------------------------------------------------------------------------
// ppc_mul
// Shift-add multiplier, one multiplier bit a cycle; stops as soon as the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module ppc_mul import ppc_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] product
);

  logic         busy_r, busy_nxt;
  logic [W-1:0] a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;

  assign done    = busy_r && (b_r == '0);
  assign product = acc_r;

  always_comb begin
    busy_nxt = busy_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        a_nxt    = a;
        b_nxt    = b;
        acc_nxt  = '0;
      end
    end else if (done) begin
      busy_nxt = 1'b0;
    end else begin
      if (b_r[0]) begin
        acc_nxt = acc_r + a_r;
      end
      a_nxt = a_r << 1;
      b_nxt = b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

endmodule

### rtl/ppc_back.sv
// ----------------------------------------------------------------------------
// ppc_back
// Turns one region's totals into the Q1.15 coefficient: variances and
// covariance on the shared multiplier, then a bit-by-bit search for the
// rounded magnitude.
// ----------------------------------------------------------------------------
module ppc_back import ppc_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int MAX_REGION_DIM = MAX_REGION_DIM_DEF,
  localparam int MAX_PAIRS = MAX_REGION_DIM * MAX_REGION_DIM,
  localparam int LOG_P     = $clog2(MAX_PAIRS),
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1),
  localparam int SUM_W     = SAMPLE_BITS + LOG_P,
  localparam int SQ_W      = 2 * SAMPLE_BITS + LOG_P,
  localparam int SNAP_W    = CNT_W + 2 * SUM_W + 3 * SQ_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  logic [SNAP_W-1:0] q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output ppc_result_t       out_res
);

  localparam int VAR_W    = 2 * SAMPLE_BITS + 2 * LOG_P;
  localparam int P_W      = 2 * VAR_W;
  localparam int PROD_W   = P_W + SCALE_SH;
  localparam int D_W      = CORR_FRAC + 1;
  localparam int CAND_MAX = 1 << CORR_FRAC;

  logic [CNT_W-1:0] q_n;
  logic [SUM_W-1:0] q_sx, q_sy;
  logic [SQ_W-1:0]  q_sxy, q_sxx, q_syy;

  bk_state_t state_r, state_nxt;
  logic issued_r, issued_nxt, out_valid_r, out_valid_nxt;
  ppc_result_t out_res_r, out_res_nxt;

  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [SUM_W-1:0]    sx_r, sx_nxt, sy_r, sy_nxt;
  logic [SQ_W-1:0]     sxy_r, sxy_nxt, sxx_r, sxx_nxt, syy_r, syy_nxt;
  logic [VAR_W-1:0]    t_r, t_nxt, vx_r, vx_nxt, vy_r, vy_nxt, c_r, c_nxt;
  logic [P_W-1:0]      p_r, p_nxt;
  logic [PROD_W-1:0]   lhs_r, lhs_nxt;
  logic [SCALE_SH-1:0] dd_r, dd_nxt;
  logic [D_W-1:0]      m_r, m_nxt;
  logic [SRCH_BW-1:0]  bit_r, bit_nxt;
  logic                neg_r, neg_nxt, degen_r, degen_nxt;

  logic              is_mul, mul_start, mul_done;
  logic [PROD_W-1:0] mul_a, mul_b, mul_p;
  logic [VAR_W-1:0]  mul_lo;
  logic [D_W-1:0]    cand, d_val, corr_val;
  logic              cand_ok;

  assign {q_n, q_sx, q_sy, q_sxy, q_sxx, q_syy} = q_data;

  ppc_mul #(.W(PROD_W)) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  assign mul_lo  = mul_p[VAR_W-1:0];
  assign cand    = m_r | (D_W'(1) << bit_r);
  assign cand_ok = cand <= D_W'(CAND_MAX);
  assign d_val   = D_W'({1'b0, cand, 1'b0} - (D_W + 2)'(1));

  always_comb begin
    if (degen_r) begin
      corr_val = '0;
    end else if (neg_r) begin
      corr_val = D_W'(0) - m_r;
    end else if (m_r > D_W'(CAND_MAX - 1)) begin
      corr_val = D_W'(CAND_MAX - 1);
    end else begin
      corr_val = m_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    n_nxt   = n_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sxy_nxt = sxy_r;
    sxx_nxt = sxx_r;
    syy_nxt = syy_r;
    t_nxt   = t_r;
    vx_nxt  = vx_r;
    vy_nxt  = vy_r;
    c_nxt   = c_r;
    p_nxt   = p_r;
    lhs_nxt = lhs_r;
    dd_nxt  = dd_r;
    m_nxt   = m_r;
    bit_nxt = bit_r;
    neg_nxt = neg_r;
    degen_nxt = degen_r;
    q_pop  = 1'b0;
    is_mul = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          n_nxt     = q_n;
          sx_nxt    = q_sx;
          sy_nxt    = q_sy;
          sxy_nxt   = q_sxy;
          sxx_nxt   = q_sxx;
          syy_nxt   = q_syy;
          degen_nxt = 1'b0;
          neg_nxt   = 1'b0;
          m_nxt     = '0;
          bit_nxt   = SRCH_BW'(CORR_FRAC);
          state_nxt = BK_VXA;
        end
      end
      BK_VXA: begin
        is_mul = 1'b1;
        mul_a  = PROD_W'(sxx_r);
        mul_b  = PROD_W'(n_r);
        if (mul_done) begin
          t_nxt     = mul_lo;
          state_nxt = BK_VXB;
        end
      end
      BK_VXB: begin
        is_mul = 1'b1;
        mul_a  = PROD_W'(sx_r);
        mul_b  = PROD_W'(sx_r);
        if (mul_done) begin
          if (t_r > mul_lo) begin
            vx_nxt    = t_r - mul_lo;
            state_nxt = BK_VYA;
          end else begin
            degen_nxt = 1'b1;
            state_nxt = BK_OUT;
          end
        end
      end
      BK_VYA: begin
        is_mul = 1'b1;
        mul_a  = PROD_W'(syy_r);
        mul_b  = PROD_W'(n_r);
        if (mul_done) begin
          t_nxt     = mul_lo;
          state_nxt = BK_VYB;
        end
      end
      BK_VYB: begin
        is_mul = 1'b1;
        mul_a  = PROD_W'(sy_r);
        mul_b  = PROD_W'(sy_r);
        if (mul_done) begin
          if (t_r > mul_lo) begin
            vy_nxt    = t_r - mul_lo;
            state_nxt = BK_CVA;
          end else begin
            degen_nxt = 1'b1;
            state_nxt = BK_OUT;
          end
        end
      end
      BK_CVA: begin
        is_mul = 1'b1;
        mul_a  = PROD_W'(sxy_r);
        mul_b  = PROD_W'(n_r);
        if (mul_done) begin
          t_nxt     = mul_lo;
          state_nxt = BK_CVB;
        end
      end
      BK_CVB: begin
        is_mul = 1'b1;
        mul_a  = PROD_W'(sx_r);
        mul_b  = PROD_W'(sy_r);
        if (mul_done) begin
          if (t_r < mul_lo) begin
            neg_nxt = 1'b1;
            c_nxt   = mul_lo - t_r;
          end else begin
            neg_nxt = 1'b0;
            c_nxt   = t_r - mul_lo;
          end
          state_nxt = BK_PV;
        end
      end
      BK_PV: begin
        is_mul = 1'b1;
        mul_a  = PROD_W'(vx_r);
        mul_b  = PROD_W'(vy_r);
        if (mul_done) begin
          p_nxt     = mul_p[P_W-1:0];
          state_nxt = BK_LHS;
        end
      end
      BK_LHS: begin
        is_mul = 1'b1;
        mul_a  = PROD_W'(c_r);
        mul_b  = PROD_W'(c_r);
        if (mul_done) begin
          lhs_nxt   = {mul_p[P_W-1:0], SCALE_SH'(0)};
          state_nxt = BK_SD;
        end
      end
      BK_SD: begin
        if (!cand_ok) begin
          // candidate above +1: drop this bit
          if (bit_r == '0) begin
            state_nxt = BK_OUT;
          end else begin
            bit_nxt = bit_r - SRCH_BW'(1);
          end
        end else begin
          is_mul = 1'b1;
          mul_a  = PROD_W'(d_val);
          mul_b  = PROD_W'(d_val);
          if (mul_done) begin
            dd_nxt    = mul_p[SCALE_SH-1:0];
            state_nxt = BK_ST;
          end
        end
      end
      BK_ST: begin
        is_mul = 1'b1;
        mul_a  = PROD_W'(p_r);
        mul_b  = PROD_W'(dd_r);
        if (mul_done) begin
          if (mul_p <= lhs_r) begin
            m_nxt = cand;
          end
          if (bit_r == '0) begin
            state_nxt = BK_OUT;
          end else begin
            bit_nxt   = bit_r - SRCH_BW'(1);
            state_nxt = BK_SD;
          end
        end
      end
      BK_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          out_res_nxt.corr  = $signed(corr_val);
          out_res_nxt.degen = degen_r;
          out_res_nxt.count = PAIR_COUNT_W'(n_r);
          state_nxt         = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    mul_start  = is_mul && !issued_r;
    issued_nxt = mul_start ? 1'b1 : (mul_done ? 1'b0 : issued_r);
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    n_r   <= n_nxt;
    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    sxy_r <= sxy_nxt;
    sxx_r <= sxx_nxt;
    syy_r <= syy_nxt;
    t_r   <= t_nxt;
    vx_r  <= vx_nxt;
    vy_r  <= vy_nxt;
    c_r   <= c_nxt;
    p_r   <= p_nxt;
    lhs_r <= lhs_nxt;
    dd_r  <= dd_nxt;
    m_r   <= m_nxt;
    bit_r <= bit_nxt;
    neg_r <= neg_nxt;
    degen_r <= degen_nxt;
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_res_r.degen) |-> (out_res_r.corr == '0))
    else $error("degenerate result with nonzero coefficient");
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == BK_SD || state_r == BK_ST || state_r == BK_OUT) |-> m_r <= D_W'(CAND_MAX))
    else $error("search magnitude above one");
  a_done_own: assert property (@(posedge clk) disable iff (!rst_n) mul_done |-> issued_r)
    else $error("multiplier finished without a request");

endmodule
